[sv/rrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared widths, codes and types of the read range set: operation kinds,
// cell commands and the records passed between the cells and the control.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned MaxRanges = 64;
  localparam int unsigned NumW      = 32;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CountW    = 7;

  localparam logic [KindW-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KindW-1:0] KIND_MARK   = 2'd1;
  localparam logic [KindW-1:0] KIND_UNMARK = 2'd2;
  localparam logic [KindW-1:0] KIND_SETLOW = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CMP,
    OP_MERGE,
    OP_EXT_END,
    OP_EXT_START,
    OP_INSERT,
    OP_SPLIT,
    OP_DELETE,
    OP_TRIM_START,
    OP_TRIM_END,
    OP_LOW_STEP,
    OP_LOW_DONE
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_LOW  = 4'b1000
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [NumW-1:0] n;
    logic [NumW:0]   n_p1;
    logic [NumW-1:0] n_m1;
    logic            n_nz;
    logic [NumW-1:0] ins_s;
    logic [NumW-1:0] ins_e;
  } cmd_t;

  typedef struct packed {
    logic            v;
    logic            b;
    logic            ge;
    logic [NumW-1:0] s;
    logic [NumW-1:0] e;
  } nb_t;

  typedef struct packed {
    logic mem;
    logic left;
    logic right;
    logic rs;
    logic re;
  } flags_t;

endpackage

[sv/rrs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_if
// Channel interfaces of the read range set: operation transactions in,
// result transactions out, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrs_in_if;
  import rrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [NumW-1:0]  number;

  modport source (output valid, kind, number, input ready);
  modport sink   (input valid, kind, number, output ready);
endinterface

interface rrs_out_if;
  import rrs_pkg::*;

  logic              valid;
  logic              ready;
  logic              was_member;
  logic [CountW-1:0] range_count;
  logic              full_res;

  modport source (output valid, was_member, range_count, full_res, input ready);
  modport sink   (input valid, was_member, range_count, full_res, output ready);
endinterface

[sv/rrs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_cell
// One slot of the range chain: holds one range and its compare flags,
// and on each command keeps, edits or takes the range of a neighbor.
// ----------------------------------------------------------------------------
module rrs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_i,
  input  rrs_pkg::cmd_t  cmd_i,
  input  rrs_pkg::nb_t   left_i,
  input  rrs_pkg::nb_t   right_i,
  output rrs_pkg::nb_t   self_o,
  output rrs_pkg::flags_t flags_o
);
  import rrs_pkg::*;

  logic            v_q, v_d;
  logic            b_q, b_d;
  logic            ge_q, ge_d;
  logic            el_q, el_d;
  logic            sr_q, sr_d;
  logic            se_q, se_d;
  logic            ee_q, ee_d;
  logic [NumW-1:0] s_q, s_d;
  logic [NumW-1:0] e_q, e_d;
  logic            bnd;
  logic            fa;

  assign bnd = b_q & ~right_i.b;
  assign fa  = ~b_q & left_i.b;

  assign self_o = '{v: v_q, b: b_q, ge: ge_q, s: s_q, e: e_q};

  assign flags_o = '{
    mem:   bnd & ge_q,
    left:  bnd & el_q,
    right: fa & v_q & sr_q,
    rs:    bnd & se_q,
    re:    bnd & ee_q
  };

  always_comb begin
    v_d  = v_q;
    b_d  = b_q;
    ge_d = ge_q;
    el_d = el_q;
    sr_d = sr_q;
    se_d = se_q;
    ee_d = ee_q;
    s_d  = s_q;
    e_d  = e_q;
    case (cmd_i.op)
      OP_CMP: begin
        b_d  = v_q & (s_q <= cmd_i.n);
        ge_d = (e_q >= cmd_i.n);
        el_d = (e_q == cmd_i.n_m1) & cmd_i.n_nz;
        sr_d = ({1'b0, s_q} == cmd_i.n_p1);
        se_d = (s_q == cmd_i.n);
        ee_d = (e_q == cmd_i.n);
      end
      OP_MERGE: begin
        if (bnd) begin
          e_d = right_i.e;
        end else if (!b_q) begin
          v_d = right_i.v;
          s_d = right_i.s;
          e_d = right_i.e;
        end
      end
      OP_EXT_END: begin
        if (bnd) begin
          e_d = cmd_i.n;
        end
      end
      OP_EXT_START: begin
        if (fa) begin
          s_d = cmd_i.n;
        end
      end
      OP_INSERT: begin
        if (fa) begin
          v_d = 1'b1;
          s_d = cmd_i.ins_s;
          e_d = cmd_i.ins_e;
        end else if (!b_q) begin
          v_d = left_i.v;
          s_d = left_i.s;
          e_d = left_i.e;
        end
      end
      OP_SPLIT: begin
        if (bnd) begin
          e_d = cmd_i.n_m1;
        end else if (fa) begin
          v_d = 1'b1;
          s_d = cmd_i.n_p1[NumW-1:0];
          e_d = left_i.e;
        end else if (!b_q) begin
          v_d = left_i.v;
          s_d = left_i.s;
          e_d = left_i.e;
        end
      end
      OP_DELETE: begin
        if (bnd || !b_q) begin
          v_d = right_i.v;
          s_d = right_i.s;
          e_d = right_i.e;
        end
      end
      OP_TRIM_START: begin
        if (bnd) begin
          s_d = cmd_i.n_p1[NumW-1:0];
        end
      end
      OP_TRIM_END: begin
        if (bnd) begin
          e_d = cmd_i.n_m1;
        end
      end
      OP_LOW_STEP: begin
        if (head_i) begin
          e_d  = right_i.e;
          ge_d = right_i.ge;
        end else begin
          v_d  = right_i.v;
          b_d  = right_i.b;
          ge_d = right_i.ge;
          s_d  = right_i.s;
          e_d  = right_i.e;
        end
      end
      OP_LOW_DONE: begin
        if (head_i) begin
          s_d = (s_q == '0) ? '0 : NumW'(1);
          e_d = ge_q ? e_q : cmd_i.n_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      b_q  <= 1'b0;
      ge_q <= 1'b0;
      el_q <= 1'b0;
      sr_q <= 1'b0;
      se_q <= 1'b0;
      ee_q <= 1'b0;
    end else begin
      v_q  <= v_d;
      b_q  <= b_d;
      ge_q <= ge_d;
      el_q <= el_d;
      sr_q <= sr_d;
      se_q <= se_d;
      ee_q <= ee_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    e_q <= e_d;
  end

endmodule

[sv/read_range_set.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_range_set
// Sorted store of disjoint, non-adjacent ranges of marked item numbers,
// kept in a chain of range cells; query, mark, unmark and set-low.
// ----------------------------------------------------------------------------
// Each operation transaction yields one result transaction with the old
// membership of the number, the range count after the operation and a full
// flag. The chain compares every cell against the number in the compare
// state and applies the edit in the update state, and the next operation
// is taken in the cycle the result is loaded. A set-low that absorbs
// ranges beyond the first drops one absorbed range per cycle into the head
// cell. A result not yet taken holds the finishing cycle. The store is
// empty after reset and needs no clearing pass.
module read_range_set #(
  parameter int unsigned MAX_RANGES = rrs_pkg::MaxRanges
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrs_in_if.sink     in_i,
  rrs_out_if.source  out_o
);
  import rrs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);

  state_e             state_q, state_d;
  logic [KindW-1:0]   kind_q;
  logic [NumW-1:0]    n_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               mem_q;
  logic               out_valid_q;
  logic               out_mem_q;
  logic [CountW-1:0]  out_cnt_q;
  logic               out_full_q;

  cmd_t               cmd;
  nb_t                cell_nb [MAX_RANGES];
  flags_t             cell_fl [MAX_RANGES];
  logic [MAX_RANGES-1:0] mem_v, left_v, right_v, rs_v, re_v;

  logic               member, left, right, rs, re;
  logic               b0, b1, full, slot_free;
  logic               fin, go_low, accept, in_ready, full_c, was_c;
  op_e                op;
  logic [NumW-1:0]    ins_s, ins_e;

  localparam nb_t HeadNb = '{v: 1'b1, b: 1'b1, ge: 1'b0, s: '0, e: '0};
  localparam nb_t TailNb = '{v: 1'b0, b: 1'b0, ge: 1'b0, s: '0, e: '0};

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    nb_t left_nb;
    nb_t right_nb;

    if (k == 0) begin : g_head
      assign left_nb = HeadNb;
    end else begin : g_mid
      assign left_nb = cell_nb[k-1];
    end

    if (k == MAX_RANGES - 1) begin : g_tail
      assign right_nb = TailNb;
    end else begin : g_body
      assign right_nb = cell_nb[k+1];
    end

    rrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .head_i  (k == 0),
      .cmd_i   (cmd),
      .left_i  (left_nb),
      .right_i (right_nb),
      .self_o  (cell_nb[k]),
      .flags_o (cell_fl[k])
    );

    assign mem_v[k]   = cell_fl[k].mem;
    assign left_v[k]  = cell_fl[k].left;
    assign right_v[k] = cell_fl[k].right;
    assign rs_v[k]    = cell_fl[k].rs;
    assign re_v[k]    = cell_fl[k].re;
  end

  assign member    = |mem_v;
  assign left      = |left_v;
  assign right     = |right_v;
  assign rs        = |rs_v;
  assign re        = |re_v;
  assign b0        = cell_nb[0].b;
  assign b1        = cell_nb[1].b;
  assign full      = (cnt_q == CntW'(MAX_RANGES));
  assign slot_free = ~out_valid_q | out_o.ready;

  assign cmd = '{
    op:    op,
    n:     n_q,
    n_p1:  {1'b0, n_q} + (NumW+1)'(1),
    n_m1:  n_q - NumW'(1),
    n_nz:  |n_q,
    ins_s: ins_s,
    ins_e: ins_e
  };

  always_comb begin
    op     = OP_NONE;
    cnt_d  = cnt_q;
    full_c = 1'b0;
    fin    = 1'b0;
    go_low = 1'b0;
    ins_s  = n_q;
    ins_e  = n_q;
    case (state_q)
      ST_CMP: begin
        op = OP_CMP;
      end
      ST_UPD: begin
        if (kind_q == KIND_SETLOW && (|n_q[NumW-1:1]) && b0) begin
          if (b1) begin
            op     = OP_LOW_STEP;
            cnt_d  = cnt_q - CntW'(1);
            go_low = 1'b1;
          end else if (slot_free) begin
            op  = OP_LOW_DONE;
            fin = 1'b1;
          end
        end else if (slot_free) begin
          fin = 1'b1;
          case (kind_q)
            KIND_MARK: begin
              if (!member) begin
                if (left && right) begin
                  op    = OP_MERGE;
                  cnt_d = cnt_q - CntW'(1);
                end else if (left) begin
                  op = OP_EXT_END;
                end else if (right) begin
                  op = OP_EXT_START;
                end else if (full) begin
                  full_c = 1'b1;
                end else begin
                  op    = OP_INSERT;
                  cnt_d = cnt_q + CntW'(1);
                end
              end
            end
            KIND_UNMARK: begin
              if (member) begin
                if (rs && re) begin
                  op    = OP_DELETE;
                  cnt_d = cnt_q - CntW'(1);
                end else if (rs) begin
                  op = OP_TRIM_START;
                end else if (re) begin
                  op = OP_TRIM_END;
                end else if (full) begin
                  full_c = 1'b1;
                end else begin
                  op    = OP_SPLIT;
                  cnt_d = cnt_q + CntW'(1);
                end
              end
            end
            KIND_SETLOW: begin
              if (|n_q[NumW-1:1]) begin
                if (full) begin
                  full_c = 1'b1;
                end else begin
                  op    = OP_INSERT;
                  ins_s = NumW'(1);
                  ins_e = n_q - NumW'(1);
                  cnt_d = cnt_q + CntW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOW: begin
        if (b1) begin
          op    = OP_LOW_STEP;
          cnt_d = cnt_q - CntW'(1);
        end else if (slot_free) begin
          op  = OP_LOW_DONE;
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready   = (state_q == ST_IDLE) | fin;
  assign accept     = in_i.valid & in_ready;
  assign in_i.ready = in_ready;
  assign was_c      = (state_q == ST_UPD) ? member : mem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = go_low ? ST_LOW : state_q;
      default: state_d = state_q;
    endcase
    if (fin) begin
      state_d = ST_IDLE;
    end
    if (accept) begin
      state_d = ST_CMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      n_q    <= in_i.number;
    end
    if (state_q == ST_UPD) begin
      mem_q <= member;
    end
    if (fin) begin
      out_mem_q  <= was_c;
      out_cnt_q  <= CountW'(cnt_d);
      out_full_q <= full_c;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.was_member  = out_mem_q;
  assign out_o.range_count = out_cnt_q;
  assign out_o.full_res    = out_full_q;

endmodule
